[rtl/cbs_pkg.sv]
// Package with types, constants and a helper function for the candle breath and shake controller.
package cbs_pkg;

  // Field widths
  localparam int unsigned MIC_W    = 10;
  localparam int unsigned DRAW_W   = 15;
  localparam int unsigned DUTY_W   = 7;
  localparam int unsigned THR_W    = 10;
  localparam int unsigned LOCK_W   = 10;
  localparam int unsigned TICK_W   = 11;
  localparam int unsigned TILT_W   = 3;
  localparam int unsigned WCNT_W   = 8;
  localparam int unsigned SUM_W    = 18;
  localparam int unsigned LIM_W    = 19;
  localparam int unsigned MOD_W    = 6;
  localparam int unsigned STEP_W   = 4;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOW_OUT  = 3'd0,
    REG_WEAK      = 3'd1,
    REG_LOCKOUT   = 3'd2,
    REG_TIMEOUT   = 3'd3,
    REG_SHAKES    = 3'd4,
    REG_RED_DUTY  = 3'd5
  } cbs_reg_e;

  // Register reset values
  localparam int unsigned BLOW_OUT_RST = 430;
  localparam int unsigned WEAK_RST     = 100;
  localparam logic [LOCK_W-1:0] LOCKOUT_RST = 10'd350;
  localparam logic [TICK_W-1:0] TIMEOUT_RST = 11'd600;
  localparam logic [TILT_W-1:0] SHAKES_RST  = 3'd3;
  localparam logic [DUTY_W-1:0] RED_RST     = 7'd95;

  // Flicker constants
  localparam logic [MOD_W-1:0]  BASE_MOD     = 6'd20;
  localparam logic [MOD_W-1:0]  ON_LIMIT     = 6'd18;
  localparam logic [DUTY_W-1:0] RED_MAX      = 7'd100;
  localparam logic [DUTY_W-1:0] GREEN_STEADY = 7'd5;
  localparam logic [DUTY_W-1:0] GREEN_EXTRA  = 7'd3;
  localparam logic [STEP_W-1:0] LAST_STEP    = 4'(DRAW_W - 1);

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } cbs_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;    // take the input beat, update tick state, start remainder
    logic step;    // one remainder step
    logic finish;  // write the result register
  } cbs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_last;
  } cbs_sts_t;

  // Result beat
  typedef struct packed {
    logic [DUTY_W-1:0] red_pct;
    logic [DUTY_W-1:0] green_pct;
    logic              candle_lit;
    logic              extra_flicker_on;
    logic              tilt_accepted;
  } cbs_res_t;

  // x mod 15 for a byte: 16 == 1 (mod 15), so add the nibbles and fold twice
  function automatic logic [3:0] mod15(input logic [7:0] x);
    logic [4:0] s;
    s = {1'b0, x[7:4]} + {1'b0, x[3:0]};
    if (s >= 5'd15) s = s - 5'd15;
    if (s >= 5'd15) s = s - 5'd15;
    return s[3:0];
  endfunction

endpackage

[rtl/cbs_if.sv]
// Valid/ready channel interfaces for input ticks and result beats.
interface cbs_in_if;
  logic                       valid;
  logic                       ready;
  logic [cbs_pkg::MIC_W-1:0]  mic_sample;
  logic                       tilt_edge;
  logic                       button_press;
  logic [cbs_pkg::DRAW_W-1:0] random_draw;

  modport source (output valid, mic_sample, tilt_edge, button_press, random_draw,
                  input ready);
  modport sink   (input valid, mic_sample, tilt_edge, button_press, random_draw,
                  output ready);
endinterface

interface cbs_out_if;
  logic                       valid;
  logic                       ready;
  logic [cbs_pkg::DUTY_W-1:0] red_pct;
  logic [cbs_pkg::DUTY_W-1:0] green_pct;
  logic                       candle_lit;
  logic                       extra_flicker_on;
  logic                       tilt_accepted;

  modport source (output valid, red_pct, green_pct, candle_lit, extra_flicker_on,
                  tilt_accepted, input ready);
  modport sink   (input valid, red_pct, green_pct, candle_lit, extra_flicker_on,
                  tilt_accepted, output ready);
endinterface

[rtl/cbs_datapath.sv]
// Datapath: configuration, tick state, bit-serial remainder unit and result register.
module cbs_datapath #(
  parameter int unsigned WINDOW_SAMPLES = 150
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cbs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cbs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [cbs_pkg::MIC_W-1:0]      mic_sample_i,
  input  logic                           tilt_edge_i,
  input  logic                           button_press_i,
  input  logic [cbs_pkg::DRAW_W-1:0]     random_draw_i,
  input  cbs_pkg::cbs_cmd_t              cmd_i,
  output cbs_pkg::cbs_sts_t              sts_o,
  output cbs_pkg::cbs_res_t              res_o
);

  localparam int unsigned LIM_W  = cbs_pkg::LIM_W;
  localparam int unsigned SUM_W  = cbs_pkg::SUM_W;
  localparam int unsigned WCNT_W = cbs_pkg::WCNT_W;
  localparam int unsigned MOD_W  = cbs_pkg::MOD_W;
  localparam int unsigned DRAW_W = cbs_pkg::DRAW_W;
  localparam int unsigned DUTY_W = cbs_pkg::DUTY_W;

  localparam logic [WCNT_W-1:0] WIN     = WCNT_W'(WINDOW_SAMPLES);
  localparam logic [LIM_W-1:0]  BO_RST  = LIM_W'((cbs_pkg::BLOW_OUT_RST + 1) * WINDOW_SAMPLES);
  localparam logic [LIM_W-1:0]  WB_RST  = LIM_W'((cbs_pkg::WEAK_RST + 1) * WINDOW_SAMPLES);

  // Configuration; average thresholds kept as sum limits: avg > t <=> sum >= (t+1)*N
  logic [LIM_W-1:0]             bo_lim_q, wb_lim_q;
  logic [cbs_pkg::LOCK_W-1:0]   slt_q;
  logic [cbs_pkg::TICK_W-1:0]   sto_q;
  logic [cbs_pkg::TILT_W-1:0]   sn_q;
  logic [DUTY_W-1:0]            red_q;
  logic [cbs_pkg::THR_W:0]      thr_p1;
  logic [LIM_W-1:0]             lim_cfg;
  logic [DUTY_W-1:0]            red_cfg;

  always_comb begin
    thr_p1  = {1'b0, cfg_data_i[cbs_pkg::THR_W-1:0]} + 11'd1;
    lim_cfg = LIM_W'(thr_p1) * LIM_W'(WINDOW_SAMPLES);
    red_cfg = (cfg_data_i[DUTY_W-1:0] > cbs_pkg::RED_MAX) ? cbs_pkg::RED_MAX
                                                          : cfg_data_i[DUTY_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bo_lim_q <= BO_RST;
      wb_lim_q <= WB_RST;
      slt_q    <= cbs_pkg::LOCKOUT_RST;
      sto_q    <= cbs_pkg::TIMEOUT_RST;
      sn_q     <= cbs_pkg::SHAKES_RST;
      red_q    <= cbs_pkg::RED_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cbs_pkg::REG_BLOW_OUT: bo_lim_q <= lim_cfg;
        cbs_pkg::REG_WEAK:     wb_lim_q <= lim_cfg;
        cbs_pkg::REG_LOCKOUT:  slt_q    <= cfg_data_i[cbs_pkg::LOCK_W-1:0];
        cbs_pkg::REG_TIMEOUT:  sto_q    <= cfg_data_i[cbs_pkg::TICK_W-1:0];
        cbs_pkg::REG_SHAKES:   sn_q     <= cfg_data_i[cbs_pkg::TILT_W-1:0];
        cbs_pkg::REG_RED_DUTY: red_q    <= red_cfg;
        default: ;
      endcase
    end
  end

  // Tick state
  logic                         lit_q,  lit_d;
  logic [WCNT_W-1:0]            wc_q,   wc_d;
  logic [SUM_W-1:0]             sum_q,  sum_d;
  logic [7:0]                   fl_q,   fl_d;
  logic [cbs_pkg::LOCK_W-1:0]   lo_q,   lo_d;
  logic [cbs_pkg::TILT_W-1:0]   tc_q,   tc_d;
  logic [cbs_pkg::TICK_W-1:0]   tst_q,  tst_d;

  // Work registers for the tick in flight
  logic [MOD_W-1:0]  mod_q,  mod_d;
  logic [DRAW_W-1:0] dvd_q;
  logic [MOD_W-1:0]  rem_q;
  logic [cbs_pkg::STEP_W-1:0] cnt_q;
  logic [DUTY_W-1:0] red_c_q,   red_c_d;
  logic [DUTY_W-1:0] green_c_q, green_c_d;
  logic              acc_q,     acc_d;
  cbs_pkg::cbs_res_t res_q;

  // Tick update, in the order: button, flicker, window, shake, timeout
  logic             lit0, lit1, judged, blow, weak_hit;
  logic [7:0]       fl1;
  logic [WCNT_W-1:0] wc_base;
  logic [SUM_W-1:0] sum_base;
  logic [SUM_W:0]   sum_add;
  logic [cbs_pkg::LOCK_W-1:0] lo1;
  logic [cbs_pkg::TILT_W-1:0] tc1;
  logic [cbs_pkg::TICK_W-1:0] tst1;

  always_comb begin
    lit0      = lit_q | button_press_i;
    fl1       = fl_q;
    mod_d     = cbs_pkg::BASE_MOD;
    red_c_d   = '0;
    green_c_d = '0;
    fl_d      = fl_q;
    wc_d      = wc_q;
    sum_d     = sum_q;
    lit1      = lit0;
    judged    = 1'b0;
    blow      = 1'b0;
    weak_hit  = 1'b0;
    wc_base   = wc_q;
    sum_base  = sum_q;
    sum_add   = '0;

    if (lit0) begin
      // flicker colors and modulus
      if (fl_q != 8'd0) begin
        fl1       = fl_q - 8'd1;
        mod_d     = cbs_pkg::BASE_MOD + MOD_W'(cbs_pkg::mod15(fl1));
        green_c_d = cbs_pkg::GREEN_EXTRA;
      end else begin
        green_c_d = cbs_pkg::GREEN_STEADY;
      end
      red_c_d = red_q;

      // judge a full window, then add this sample
      judged   = (wc_q >= WIN);
      blow     = judged && ({1'b0, sum_q} >= bo_lim_q);
      weak_hit = judged && !blow && ({1'b0, sum_q} >= wb_lim_q);
      fl_d     = weak_hit ? WIN : fl1;
      lit1     = !blow;
      if (judged) begin
        wc_base  = '0;
        sum_base = '0;
      end
      wc_d    = (wc_base != '1) ? wc_base + 1'b1 : wc_base;
      sum_add = {1'b0, sum_base} + (SUM_W+1)'(mic_sample_i);
      sum_d   = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
    end

    // accepted tilt
    acc_d = tilt_edge_i && (lo_q == '0);
    lo1   = lo_q;
    tc1   = tc_q;
    tst1  = tst_q;
    if (acc_d) begin
      lo1  = slt_q;
      tc1  = (tc_q != '1) ? tc_q + 1'b1 : tc_q;
      tst1 = '0;
    end

    // lockout countdown and toggle at its end
    lo_d  = lo1;
    tc_d  = tc1;
    lit_d = lit1;
    if (lo1 != '0) begin
      lo_d = lo1 - 1'b1;
      if (lo_d == '0 && tc1 >= sn_q) begin
        lit_d = ~lit1;
        tc_d  = '0;
      end
    end

    // timeout
    if (tst1 > sto_q) tc_d = '0;
    tst_d = (tst1 != '1) ? tst1 + 1'b1 : tst1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lit_q <= 1'b1;
      wc_q  <= '0;
      sum_q <= '0;
      fl_q  <= '0;
      lo_q  <= '0;
      tc_q  <= '0;
      tst_q <= '0;
    end else if (cmd_i.load) begin
      lit_q <= lit_d;
      wc_q  <= wc_d;
      sum_q <= sum_d;
      fl_q  <= fl_d;
      lo_q  <= lo_d;
      tc_q  <= tc_d;
      tst_q <= tst_d;
    end
  end

  // Restoring remainder, one dividend bit per step
  logic [MOD_W:0] trial;
  always_comb begin
    trial = {rem_q, dvd_q[DRAW_W-1]};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mod_q     <= mod_d;
      dvd_q     <= random_draw_i;
      rem_q     <= '0;
      cnt_q     <= '0;
      red_c_q   <= red_c_d;
      green_c_q <= green_c_d;
      acc_q     <= acc_d;
    end else if (cmd_i.step) begin
      dvd_q <= {dvd_q[DRAW_W-2:0], 1'b0};
      cnt_q <= cnt_q + 1'b1;
      if (trial >= {1'b0, mod_q}) rem_q <= MOD_W'(trial - {1'b0, mod_q});
      else                        rem_q <= trial[MOD_W-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_q.red_pct          <= (rem_q <= cbs_pkg::ON_LIMIT) ? red_c_q : '0;
      res_q.green_pct        <= (rem_q <= cbs_pkg::ON_LIMIT) ? green_c_q : '0;
      res_q.candle_lit       <= lit_q;
      res_q.extra_flicker_on <= (fl_q != 8'd0);
      res_q.tilt_accepted    <= acc_q;
    end
  end

  assign sts_o.div_last = (cnt_q == cbs_pkg::LAST_STEP);
  assign res_o          = res_q;

  // Checks
  a_rem_below_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |=> (rem_q < mod_q))
    else $error("remainder not below modulus");

  a_window_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wc_q <= WIN) && (fl_q <= WIN))
    else $error("window or flicker count beyond window size");

endmodule

[rtl/cbs_ctrl.sv]
// Controller: sequences take, remainder steps and result write for each tick.
module cbs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  cbs_pkg::cbs_sts_t sts_i,
  output cbs_pkg::cbs_cmd_t cmd_o
);

  cbs_pkg::cbs_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic                slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cbs_pkg::ST_IDLE:   if (in_valid_i) state_d = cbs_pkg::ST_DIVIDE;
      cbs_pkg::ST_DIVIDE: if (sts_i.div_last) state_d = cbs_pkg::ST_EMIT;
      cbs_pkg::ST_EMIT:   if (slot_free) state_d = cbs_pkg::ST_IDLE;
      default:            state_d = cbs_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    case (state_q)
      cbs_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      cbs_pkg::ST_DIVIDE: cmd_o.step = 1'b1;
      cbs_pkg::ST_EMIT:   cmd_o.finish = slot_free;
      default: ;
    endcase
  end

  // Result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish)     out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cbs_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // Checks
  a_div_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cbs_pkg::ST_DIVIDE && sts_i.div_last) |=> (state_q == cbs_pkg::ST_EMIT))
    else $error("remainder end did not lead to result write");

  a_valid_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.finish))
    else $error("result valid raised without a result write");

endmodule

[rtl/candle_breath_shake_controller.sv]
// Top level of the candle breath and shake controller.
//
//   channel  | dir | signals
//   ---------+-----+---------------------------------------------------------
//   in_ch    | in  | valid, ready, mic_sample, tilt_edge, button_press, random_draw
//   out_ch   | out | valid, ready, red_pct, green_pct, candle_lit,
//            |     | extra_flicker_on, tilt_accepted
//   cfg      | in  | cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// Each tick takes the beat, runs the bit-serial remainder of random_draw by
// the flicker modulus one dividend bit per step, then writes the result.
// Reset restores the configuration registers and tick state at once; no clearing pass.
// A result held by the sink stalls the write of the next result; the next
// input beat is taken while it waits, but none after it until that write.
module candle_breath_shake_controller #(
  parameter int unsigned WINDOW_SAMPLES = 150
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  cbs_in_if.sink                         in_ch,
  cbs_out_if.source                      out_ch,
  input  logic                           cfg_we_i,
  input  logic [cbs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cbs_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  cbs_pkg::cbs_cmd_t cmd;
  cbs_pkg::cbs_sts_t sts;
  cbs_pkg::cbs_res_t res;

  cbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cbs_datapath #(
    .WINDOW_SAMPLES (WINDOW_SAMPLES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .mic_sample_i   (in_ch.mic_sample),
    .tilt_edge_i    (in_ch.tilt_edge),
    .button_press_i (in_ch.button_press),
    .random_draw_i  (in_ch.random_draw),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .res_o          (res)
  );

  // Result beat
  assign out_ch.red_pct          = res.red_pct;
  assign out_ch.green_pct        = res.green_pct;
  assign out_ch.candle_lit       = res.candle_lit;
  assign out_ch.extra_flicker_on = res.extra_flicker_on;
  assign out_ch.tilt_accepted    = res.tilt_accepted;

endmodule
